[rtl/swsr_pkg.sv]
// swsr_pkg: shared types, codes and reset values for the single-wire sensor receiver
// no dependencies; imported by every rtl module and by the checker
`timescale 1ns / 1ps

package swsr_pkg;

  localparam int COUNTER_WIDTH_DEF = 20;
  localparam int TIMEOUT_W         = 20;
  localparam int CFG_ADDR_W        = 5;
  localparam int CFG_DATA_W        = 32;

  // register reset values
  localparam logic [15:0] START_LOW_RST    = 16'd18000;
  localparam logic [7:0]  RELEASE_RST      = 8'd30;
  localparam logic [7:0]  SAMPLE_DELAY_RST = 8'd40;
  localparam logic [19:0] TIMEOUT_RST      = 20'd100000;
  localparam logic [3:0]  FRAME_BYTES_RST  = 4'd5;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_START_LOW    = 3'd0;
  localparam logic [2:0] REG_RELEASE      = 3'd1;
  localparam logic [2:0] REG_SAMPLE_DELAY = 3'd2;
  localparam logic [2:0] REG_TIMEOUT      = 3'd3;
  localparam logic [2:0] REG_FRAME_BYTES  = 3'd4;

  // input word kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_LOW = 4'd1,
    PH_RELEASE   = 4'd2,
    PH_RESP_LOW  = 4'd3,
    PH_RESP_HIGH = 4'd4,
    PH_RESP_END  = 4'd5,
    PH_GAP       = 4'd6,
    PH_DELAY     = 4'd7,
    PH_HIGH      = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_RESPONDED = 3'd1,
    EV_BYTE      = 3'd2,
    EV_RESP_TO   = 3'd3,
    EV_BIT_TO    = 3'd4
  } event_t;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [7:0]  release_ticks;
    logic [7:0]  sample_delay_ticks;
    logic [19:0] timeout_ticks;
    logic [3:0]  frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    event_t     event_res;
    logic [7:0] data_byte;
    logic       last_byte;
  } res_t;

endpackage

[rtl/swsr_cfg_regs.sv]
// swsr_cfg_regs: apb-style configuration registers of the receiver
// depends on swsr_pkg (cfg_t, register indexes, reset values)
`timescale 1ns / 1ps

module swsr_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [swsr_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [swsr_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [swsr_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready,
  output swsr_pkg::cfg_t                       cfg
);
  import swsr_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_ticks    <= START_LOW_RST;
      cfg_r.release_ticks      <= RELEASE_RST;
      cfg_r.sample_delay_ticks <= SAMPLE_DELAY_RST;
      cfg_r.timeout_ticks      <= TIMEOUT_RST;
      cfg_r.frame_bytes        <= FRAME_BYTES_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START_LOW:    cfg_r.start_low_ticks    <= cfg_pwdata[15:0];
        REG_RELEASE:      cfg_r.release_ticks      <= cfg_pwdata[7:0];
        REG_SAMPLE_DELAY: cfg_r.sample_delay_ticks <= cfg_pwdata[7:0];
        REG_TIMEOUT:      cfg_r.timeout_ticks      <= cfg_pwdata[19:0];
        REG_FRAME_BYTES:  cfg_r.frame_bytes        <= cfg_pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_LOW:    cfg_prdata = {16'd0, cfg_r.start_low_ticks};
      REG_RELEASE:      cfg_prdata = {24'd0, cfg_r.release_ticks};
      REG_SAMPLE_DELAY: cfg_prdata = {24'd0, cfg_r.sample_delay_ticks};
      REG_TIMEOUT:      cfg_prdata = {12'd0, cfg_r.timeout_ticks};
      REG_FRAME_BYTES:  cfg_prdata = {28'd0, cfg_r.frame_bytes};
      default:          cfg_prdata = '0;
    endcase
  end

endmodule

[rtl/swsr_core.sv]
// swsr_core: phase state, tick counter and bit/byte assembly, one word per cycle while acc is set
// depends on swsr_pkg (phase_t, event_t, cfg_t, res_t)
`timescale 1ns / 1ps

module swsr_core #(
  parameter int CounterWidth = swsr_pkg::COUNTER_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  logic           kind,
  input  logic           line,
  input  swsr_pkg::cfg_t cfg,
  output swsr_pkg::res_t res
);
  import swsr_pkg::*;

  localparam int CmpW = (CounterWidth > TIMEOUT_W) ? CounterWidth : TIMEOUT_W;

  phase_t                  phase_r, phase_nxt;
  logic [CounterWidth-1:0] tick_r, tick_nxt, tick_inc;
  logic [7:0]              shift_r, shift_nxt, shift_smp;
  logic [2:0]              bit_r, bit_nxt, bit_inc;
  logic [3:0]              byte_r, byte_nxt, byte_inc;
  logic [CmpW-1:0]         inc_ext;
  logic                    expired, start_done, rel_done, smp_done, frame_end;

  // saturating tick count
  assign tick_inc   = (&tick_r) ? tick_r : tick_r + CounterWidth'(1);
  assign inc_ext    = CmpW'(tick_inc);
  assign expired    = inc_ext >= CmpW'(cfg.timeout_ticks);
  assign start_done = inc_ext >= CmpW'(cfg.start_low_ticks);
  assign rel_done   = inc_ext >= CmpW'(cfg.release_ticks);
  assign smp_done   = inc_ext >= CmpW'(cfg.sample_delay_ticks);
  assign shift_smp  = {shift_r[6:0], line};
  assign bit_inc    = bit_r + 3'd1;
  assign byte_inc   = byte_r + 4'd1;
  // frame length 0 ends the frame on the first byte
  assign frame_end  = (byte_inc >= cfg.frame_bytes) || (byte_inc == 4'd0);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (kind == KIND_START) begin
      phase_nxt = PH_START_LOW;
    end else begin
      unique case (phase_r)
        PH_IDLE:      phase_nxt = PH_IDLE;
        PH_START_LOW: if (start_done) phase_nxt = PH_RELEASE;
        PH_RELEASE:   if (rel_done) phase_nxt = PH_RESP_LOW;
        PH_RESP_LOW: begin
          if (!line) phase_nxt = PH_RESP_HIGH;
          else if (expired) phase_nxt = PH_IDLE;
        end
        PH_RESP_HIGH: begin
          if (line) phase_nxt = PH_RESP_END;
          else if (expired) phase_nxt = PH_IDLE;
        end
        PH_RESP_END: begin
          if (!line) phase_nxt = PH_GAP;
          else if (expired) phase_nxt = PH_IDLE;
        end
        PH_GAP: begin
          if (line) phase_nxt = PH_DELAY;
          else if (expired) phase_nxt = PH_IDLE;
        end
        PH_DELAY: begin
          if (smp_done) begin
            if (line) phase_nxt = PH_HIGH;
            else if (bit_inc == 3'd0 && frame_end) phase_nxt = PH_IDLE;
            else phase_nxt = PH_GAP;
          end
        end
        PH_HIGH: begin
          if (!line) begin
            if (bit_r == 3'd0 && frame_end) phase_nxt = PH_IDLE;
            else phase_nxt = PH_GAP;
          end else if (expired) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    tick_nxt      = tick_r;
    shift_nxt     = shift_r;
    bit_nxt       = bit_r;
    byte_nxt      = byte_r;
    res.event_res = EV_NONE;
    res.data_byte = 8'd0;
    res.last_byte = 1'b0;
    if (kind == KIND_START) begin
      tick_nxt  = '0;
      shift_nxt = 8'd0;
      bit_nxt   = 3'd0;
      byte_nxt  = 4'd0;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_START_LOW: tick_nxt = start_done ? '0 : tick_inc;
        PH_RELEASE:   tick_nxt = rel_done ? '0 : tick_inc;
        PH_RESP_LOW: begin
          if (!line) begin
            tick_nxt = '0;
          end else begin
            tick_nxt = tick_inc;
            if (expired) res.event_res = EV_RESP_TO;
          end
        end
        PH_RESP_HIGH: begin
          if (line) begin
            tick_nxt      = '0;
            res.event_res = EV_RESPONDED;
          end else begin
            tick_nxt = tick_inc;
            if (expired) res.event_res = EV_RESP_TO;
          end
        end
        PH_RESP_END: begin
          if (!line) begin
            tick_nxt  = '0;
            shift_nxt = 8'd0;
            bit_nxt   = 3'd0;
            byte_nxt  = 4'd0;
          end else begin
            tick_nxt = tick_inc;
            if (expired) res.event_res = EV_RESP_TO;
          end
        end
        PH_GAP: begin
          if (line) begin
            tick_nxt = '0;
          end else begin
            tick_nxt = tick_inc;
            if (expired) res.event_res = EV_BIT_TO;
          end
        end
        PH_DELAY: begin
          tick_nxt = tick_inc;
          if (smp_done) begin
            tick_nxt  = '0;
            shift_nxt = shift_smp;
            bit_nxt   = bit_inc;
            // a zero bit completes on the sampling tick
            if (!line && bit_inc == 3'd0) begin
              res.event_res = EV_BYTE;
              res.data_byte = shift_smp;
              res.last_byte = frame_end;
              byte_nxt      = byte_inc;
              shift_nxt     = 8'd0;
            end
          end
        end
        PH_HIGH: begin
          if (!line) begin
            tick_nxt = '0;
            if (bit_r == 3'd0) begin
              res.event_res = EV_BYTE;
              res.data_byte = shift_r;
              res.last_byte = frame_end;
              byte_nxt      = byte_inc;
              shift_nxt     = 8'd0;
            end
          end else begin
            tick_nxt = tick_inc;
            if (expired) res.event_res = EV_BIT_TO;
          end
        end
        default: begin
        end
      endcase
    end
    res.drive_low = (phase_nxt == PH_START_LOW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      shift_r <= 8'd0;
      bit_r   <= 3'd0;
      byte_r  <= 4'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      shift_r <= shift_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
    end
  end

endmodule

[rtl/swsr_out_buf.sv]
// swsr_out_buf: result register with a skid stage between core and output channel
// depends on swsr_pkg (res_t)
`timescale 1ns / 1ps

module swsr_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  swsr_pkg::res_t res,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output swsr_pkg::res_t out_res
);
  import swsr_pkg::*;

  logic out_valid_r, skid_valid_r;
  res_t out_res_r, skid_res_r;
  logic out_free;

  assign in_ready  = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_free  = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r  <= skid_valid_r | res_valid;
        skid_valid_r <= 1'b0;
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end
    if (res_valid && !out_free) begin
      skid_res_r <= res;
    end
  end

endmodule

[rtl/single_wire_sensor_frame_receiver.sv]
// channel | dir | tdata                   | tuser        | tlast
// in_     | in  | [0] line_level          | [0] kind     | -
// out_    | out | [0] drive_low [8:1] byte | [2:0] event  | last_byte
// cfg_    | in  | apb registers at byte address 4*index, 32-bit data
//
// one word per clock while in_tready is up: each tick or start word is worked in a single pass
// from the phase/counter registers into the result register
// a skid stage behind the result register keeps in_tready up for one
// extra word while out_tready is low; once that word is held there, in_tready drops
// rst_n is synchronous: phase goes idle, counters clear, registers take
// their reset values; no clearing pass
// an accepted word's result goes into the result register, by way of the skid stage when out_ is stalled
// top level: depends on swsr_pkg, swsr_cfg_regs, swsr_core, swsr_out_buf
`timescale 1ns / 1ps

module single_wire_sensor_frame_receiver #(
  parameter int COUNTER_WIDTH = swsr_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [0] line_level
  input  logic                            in_tuser,   // [0] kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [0] drive_low, [8:1] data_byte
  output logic [2:0]                      out_tuser,  // [2:0] event_res
  output logic                            out_tlast,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [swsr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [swsr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [swsr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import swsr_pkg::*;

  cfg_t cfg;
  res_t core_res, out_res;
  logic acc;

  assign acc = in_tvalid & in_tready;

  swsr_cfg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  swsr_core #(
    .CounterWidth (COUNTER_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .kind  (in_tuser),
    .line  (in_tdata[0]),
    .cfg   (cfg),
    .res   (core_res)
  );

  swsr_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (acc),
    .res       (core_res),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {7'd0, out_res.data_byte, out_res.drive_low};
  assign out_tuser = out_res.event_res;
  assign out_tlast = out_res.last_byte;

endmodule

[rtl/swsr_checker.sv]
// swsr_checker: port-level assertions for the receiver, bound to the top level
// depends on swsr_pkg (event codes, input kinds)
`timescale 1ns / 1ps

module swsr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import swsr_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result word changed");

  // a start word shows up as the first line-low result when the output is free
  a_start_drive: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == KIND_START && (!out_tvalid || out_tready)
      |=> out_tvalid && out_tdata[0] && out_tuser == EV_NONE && !out_tlast)
    else $error("start word did not drive the line low");

  // byte fields only on a byte event, never while driving the line
  a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_BYTE |-> out_tdata[8:1] == 8'd0 && !out_tlast)
    else $error("byte fields set without a byte event");

  a_byte_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_BYTE |-> !out_tdata[0] && out_tdata[15:9] == 7'd0)
    else $error("byte reported while line driven");

endmodule

bind single_wire_sensor_frame_receiver swsr_checker u_swsr_checker (.*);
